FILE: rtl/core/single_source_shortest_paths_top_assert.svh
// assertion macros for the shortest path block
// used by the top level, no other dependencies
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_TOP_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_TOP_ASSERT_SVH

// consequence holds in the same cycle
`define SSSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the next cycle
`define SSSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/sssp_pkg.sv
// shared types and constants of the shortest path block
// no dependencies
`timescale 1ns / 1ps

package sssp_pkg;

   localparam int DIST_BITS = 21;
   localparam int VTX_BITS  = 4;
   localparam logic signed [DIST_BITS-1:0] DIST_MAX = 21'sd1048575;
   localparam logic signed [DIST_BITS-1:0] DIST_MIN = -21'sd1048576;

   // configuration register indexes
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_VERTEX = 1'b1;

   // contents of one vertex cell
   typedef struct packed {
      logic signed [DIST_BITS-1:0] path_dist;
      logic                        known;
      logic [VTX_BITS-1:0]         pred;
      logic                        pred_valid;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                        init;
      logic                        src_ok;
      logic [VTX_BITS-1:0]         src;
      logic                        shift;
      logic                        relax;
      logic [VTX_BITS-1:0]         to;
      logic [VTX_BITS-1:0]         from;
      logic signed [DIST_BITS-1:0] cand;
   } cell_ctl_type;

endpackage

FILE: rtl/core/sssp_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sssp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: rtl/core/sssp_cell.sv
// one vertex cell: distance, reached flag and predecessor of one vertex
// depends on sssp_pkg
`timescale 1ns / 1ps

module sssp_cell
   import sssp_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    shift_in,
   output entry_type    entry
);

   entry_type entry_ff;
   logic      hit;

   // relax applies when this cell is the target and is unreached or the candidate improves
   assign hit = ctl.relax && (ctl.to == VTX_BITS'(INDEX)) &&
                (!entry_ff.known || (ctl.cand < entry_ff.path_dist));

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (ctl.init) begin
         entry_ff.path_dist  <= '0;
         entry_ff.known      <= ctl.src_ok && (ctl.src == VTX_BITS'(INDEX));
         entry_ff.pred       <= '0;
         entry_ff.pred_valid <= 1'b0;
      end else if (ctl.shift) begin
         entry_ff <= shift_in;
      end else if (hit) begin
         entry_ff.path_dist  <= ctl.cand;
         entry_ff.known      <= 1'b1;
         entry_ff.pred       <= ctl.from;
         entry_ff.pred_valid <= 1'b1;
      end
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/core/single_source_shortest_paths_top.sv
// shortest paths by repeated relaxation: matrix ram, sequencer and a row of vertex cells
// depends on sssp_pkg, sssp_ram, sssp_cell and the assertion header
// Loading: one matrix entry per cycle while busy is low.
// Compute: an init state, V*V*V relaxations one per cycle (one matrix ram read each), then a drain state.
// A source not below V skips the relaxations and drain and goes from init to results.
// Results: V results on consecutive cycles, each registered from the output state that follows the drain.
// Then a clear of all MAX_VERTICES*MAX_VERTICES matrix entries (256 by default) with busy high.
// Synchronous reset: registers to defaults, then the same matrix clear before busy drops.
// Results cannot be stalled; they stream out one per cycle.
`timescale 1ns / 1ps
`include "single_source_shortest_paths_top_assert.svh"

module single_source_shortest_paths_top
   import sssp_pkg::*;
#(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [3:0]                     req_from_vertex,
   input  logic [3:0]                     req_to_vertex,
   input  logic signed [15:0]             req_edge_weight,
   input  logic                           req_end_of_graph,
   output logic                           rsp_valid,
   output logic [3:0]                     rsp_vertex_id,
   output logic signed [DIST_BITS-1:0]    rsp_path_length,
   output logic                           rsp_reachable,
   output logic [3:0]                     rsp_parent_vertex,
   output logic                           rsp_has_parent,
   output logic                           rsp_last_result,
   input  logic                           csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]        csr_index,
   input  logic [4:0]                     csr_write_data
);

   localparam int NCELL  = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int CW     = $clog2(NCELL);
   localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
   localparam int AW     = $clog2(DEPTH);
   localparam int WSTORE = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
   localparam int SUMW   = DIST_BITS + 1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_INIT, ST_RUN, ST_DRAIN, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [4:0]  vertex_count_ff;
   logic [3:0]  start_vertex_ff;
   logic [AW-1:0] clr_ff;
   logic [CW-1:0] r_ff, u_ff, v_ff, o_ff, nvm1_ff;
   logic        b_valid_ff, b_first_ff;
   logic [CW-1:0] b_u_ff, b_v_ff;
   logic signed [DIST_BITS-1:0] du_ff;
   logic        ku_ff;

   logic        accept, in_ok;
   logic [AW-1:0] load_addr, ram_waddr, ram_raddr;
   logic        ram_we;
   logic [WSTORE-1:0] ram_wdata, ram_rdata;
   logic [CW:0] nv_calc;
   logic        src_ok;
   logic signed [DIST_BITS-1:0] du_eff, cand;
   logic        ku_eff, relax, self_imp;
   logic signed [SUMW-1:0] wext, sum;
   cell_ctl_type ctl;
   entry_type   cell_q [NCELL];

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= 5'd16;
         start_vertex_ff <= 4'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_write_data;
            CSR_START_VERTEX: start_vertex_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // vertex count clamped to the cell row, zero taken as one
   always_comb begin
      if (vertex_count_ff == 5'd0) begin
         nv_calc = (CW+1)'(1);
      end else if (int'(vertex_count_ff) > NCELL) begin
         nv_calc = (CW+1)'(NCELL);
      end else begin
         nv_calc = vertex_count_ff[CW:0];
      end
   end
   assign src_ok = int'(start_vertex_ff) < int'(nv_calc);

   // matrix ram port selection
   assign in_ok = (int'(req_from_vertex) < MAX_VERTICES) &&
                  (int'(req_to_vertex) < MAX_VERTICES);
   assign load_addr = AW'(int'(req_from_vertex) * MAX_VERTICES + int'(req_to_vertex));
   assign ram_raddr = AW'(u_ff) * AW'(MAX_VERTICES) + AW'(v_ff);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = load_addr;
      ram_wdata = req_edge_weight[WSTORE-1:0];
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (accept && in_ok) begin
         ram_we = 1'b1;
      end
   end

   sssp_ram #(
      .WIDTH (WSTORE),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // source distance: fetched from the cells at the head of a row, tracked after
   assign du_eff = b_first_ff ? cell_q[b_u_ff].path_dist : du_ff;
   assign ku_eff = b_first_ff ? cell_q[b_u_ff].known : ku_ff;

   // candidate distance with saturation
   assign wext = {{(SUMW-WSTORE){ram_rdata[WSTORE-1]}}, ram_rdata};
   assign sum  = SUMW'(du_eff) + wext;
   always_comb begin
      if (sum > SUMW'(DIST_MAX)) begin
         cand = DIST_MAX;
      end else if (sum < SUMW'(DIST_MIN)) begin
         cand = DIST_MIN;
      end else begin
         cand = sum[DIST_BITS-1:0];
      end
   end
   assign relax    = b_valid_ff && (ram_rdata != '0) && ku_eff;
   assign self_imp = relax && (b_v_ff == b_u_ff) && (cand < du_eff);

   // broadcast to the cell row
   always_comb begin
      ctl.init   = (state_ff == ST_INIT);
      ctl.src_ok = src_ok;
      ctl.src    = start_vertex_ff;
      ctl.shift  = (state_ff == ST_OUT);
      ctl.relax  = relax;
      ctl.to     = VTX_BITS'(b_v_ff);
      ctl.from   = VTX_BITS'(b_u_ff);
      ctl.cand   = cand;
   end

   // cell row, shifting toward cell zero during readout
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      entry_type nxt;
      if (i == NCELL - 1) begin : g_end
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cell_q[i+1];
      end
      sssp_cell #(
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .shift_in (nxt),
         .entry    (cell_q[i])
      );
   end

   // sequencer and registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         r_ff            <= '0;
         u_ff            <= '0;
         v_ff            <= '0;
         o_ff            <= '0;
         nvm1_ff         <= '0;
         b_valid_ff      <= 1'b0;
         b_first_ff      <= 1'b0;
         b_u_ff          <= '0;
         b_v_ff          <= '0;
         du_ff           <= '0;
         ku_ff           <= 1'b0;
         rsp_valid       <= 1'b0;
         rsp_vertex_id   <= '0;
         rsp_path_length <= '0;
         rsp_reachable   <= 1'b0;
         rsp_parent_vertex <= '0;
         rsp_has_parent  <= 1'b0;
         rsp_last_result <= 1'b0;
      end else begin
         rsp_valid  <= (state_ff == ST_OUT);
         b_valid_ff <= (state_ff == ST_RUN);
         b_u_ff     <= u_ff;
         b_v_ff     <= v_ff;
         b_first_ff <= (v_ff == '0);
         du_ff      <= self_imp ? cand : du_eff;
         ku_ff      <= ku_eff;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept && req_end_of_graph) begin
                  state_ff <= ST_INIT;
               end
            end
            ST_INIT: begin
               nvm1_ff  <= CW'(nv_calc - 1'b1);
               r_ff     <= '0;
               u_ff     <= '0;
               v_ff     <= '0;
               o_ff     <= '0;
               state_ff <= src_ok ? ST_RUN : ST_OUT;
            end
            ST_RUN: begin
               if (v_ff != nvm1_ff) begin
                  v_ff <= v_ff + 1'b1;
               end else begin
                  v_ff <= '0;
                  if (u_ff != nvm1_ff) begin
                     u_ff <= u_ff + 1'b1;
                  end else begin
                     u_ff <= '0;
                     r_ff <= r_ff + 1'b1;
                     if (r_ff == nvm1_ff) begin
                        state_ff <= ST_DRAIN;
                     end
                  end
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_vertex_id     <= 4'(o_ff);
               rsp_path_length   <= cell_q[0].known ? cell_q[0].path_dist : '0;
               rsp_reachable     <= cell_q[0].known;
               rsp_parent_vertex <= (cell_q[0].known && cell_q[0].pred_valid) ?
                                    cell_q[0].pred : '0;
               rsp_has_parent    <= cell_q[0].known && cell_q[0].pred_valid;
               rsp_last_result   <= (o_ff == nvm1_ff);
               o_ff              <= o_ff + 1'b1;
               if (o_ff == nvm1_ff) begin
                  clr_ff   <= '0;
                  state_ff <= ST_CLEAR;
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   // checks
   `SSSP_ASSERT_SAME(a_rsp_while_busy, clock, reset, rsp_valid, busy, "result while idle")
   `SSSP_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_valid && rsp_last_result, !rsp_valid, "result after last")
   `SSSP_ASSERT_SAME(a_relax_in_run, clock, reset, b_valid_ff, state_ff == ST_RUN || state_ff == ST_DRAIN, "relax outside compute")
   `SSSP_ASSERT_NEXT(a_end_starts, clock, reset, start && !busy && req_end_of_graph, busy, "end of graph did not start run")

endmodule

FILE: tb/tb_single_source_shortest_paths_top.sv
// testbench for the shortest path block: loads graphs, checks every vertex result
// depends on sssp_pkg and single_source_shortest_paths_top
`timescale 1ns / 1ps

module tb_single_source_shortest_paths_top;
   import sssp_pkg::*;

   typedef struct {
      logic [3:0]         from_v;
      logic [3:0]         to_v;
      logic signed [15:0] weight;
      logic               last_entry;
   } edge_item_type;

   typedef struct {
      logic [3:0]                  vertex;
      logic signed [DIST_BITS-1:0] path_dist;
      logic                        reach;
      logic [3:0]                  parent;
      logic                        parent_ok;
      logic                        last;
   } vertex_result_type;

   localparam int WATCHDOG_LIMIT = 30000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [3:0] req_from_vertex = 0;
   logic [3:0] req_to_vertex = 0;
   logic signed [15:0] req_edge_weight = 0;
   logic req_end_of_graph = 0;
   logic rsp_valid;
   logic [3:0] rsp_vertex_id;
   logic signed [DIST_BITS-1:0] rsp_path_length;
   logic rsp_reachable;
   logic [3:0] rsp_parent_vertex;
   logic rsp_has_parent;
   logic rsp_last_result;
   logic csr_write_enable = 0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_VERTEX_COUNT;
   logic [4:0] csr_write_data = 0;

   single_source_shortest_paths_top dut (.*);

   // model state
   logic signed [15:0] adj_matrix [16][16];
   logic [4:0] model_vertex_count = 16;
   logic [3:0] model_source = 0;

   edge_item_type     entry_queue [$];
   vertex_result_type expected_paths [$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  sending = 0;
   bit  no_gaps = 0;
   int  gap_left = 0;
   int  item_total = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (adj_matrix[i, j]) adj_matrix[i][j] = 0;
   end

   // store one entry; on the final entry run the relaxation rounds
   task automatic load_edge_and_solve(edge_item_type it);
      int nv, dist_v [16], cand;
      bit known [16], pvalid [16];
      logic [3:0] pred [16];
      vertex_result_type r;
      adj_matrix[it.from_v][it.to_v] = it.weight;
      if (!it.last_entry) return;
      nv = model_vertex_count;
      if (nv < 1) nv = 1;
      if (nv > 16) nv = 16;
      for (int v = 0; v < 16; v++) begin
         dist_v[v] = 0; known[v] = 0; pred[v] = 0; pvalid[v] = 0;
      end
      if (model_source < nv) begin
         known[model_source] = 1;
         for (int rnd = 0; rnd < nv; rnd++)
            for (int u = 0; u < nv; u++)
               for (int v = 0; v < nv; v++) begin
                  if (adj_matrix[u][v] == 0 || !known[u]) continue;
                  cand = dist_v[u] + int'(adj_matrix[u][v]);
                  if (cand > 1048575) cand = 1048575;
                  if (cand < -1048576) cand = -1048576;
                  if (!known[v] || cand < dist_v[v]) begin
                     dist_v[v] = cand; known[v] = 1; pred[v] = 4'(u); pvalid[v] = 1;
                  end
               end
      end
      for (int v = 0; v < nv; v++) begin
         r.vertex = 4'(v);
         r.path_dist = known[v] ? DIST_BITS'(dist_v[v]) : '0;
         r.reach = known[v];
         r.parent = (known[v] && pvalid[v]) ? pred[v] : 4'd0;
         r.parent_ok = known[v] && pvalid[v];
         r.last = (v + 1 == nv);
         expected_paths.push_back(r);
      end
      foreach (adj_matrix[i, j]) adj_matrix[i][j] = 0;
   endtask

   // driver: hold each transaction until start && !busy, random gaps between
   always @(posedge clock) begin
      edge_item_type cur;
      if (!reset) begin
         if (start && !busy) begin
            cur.from_v = req_from_vertex;
            cur.to_v = req_to_vertex;
            cur.weight = req_edge_weight;
            cur.last_entry = req_end_of_graph;
            load_edge_and_solve(cur);
            sending = 0;
         end
         if (!sending) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (entry_queue.size() > 0) begin
               cur = entry_queue.pop_front();
               req_from_vertex <= cur.from_v;
               req_to_vertex <= cur.to_v;
               req_edge_weight <= cur.weight;
               req_end_of_graph <= cur.last_entry;
               sending = 1;
               if ($urandom_range(0, 40) == 0) no_gaps = !no_gaps;
               gap_left = no_gaps ? 0 : $urandom_range(0, 9);
            end
         end
         start <= sending;
      end
   end

   // monitor: every strobed result against the oldest expectation
   always @(posedge clock) begin
      vertex_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_paths.size() == 0) begin
            $error("unexpected result for vertex %0d", rsp_vertex_id);
            mismatches++;
         end else begin
            e = expected_paths.pop_front();
            if (rsp_vertex_id !== e.vertex) begin
               $error("vertex_id exp %0d got %0d", e.vertex, rsp_vertex_id); mismatches++;
            end
            if (rsp_path_length !== e.path_dist) begin
               $error("path_length exp %0d got %0d", e.path_dist, rsp_path_length);
               mismatches++;
            end
            if (rsp_reachable !== e.reach) begin
               $error("reachable exp %0d got %0d", e.reach, rsp_reachable); mismatches++;
            end
            if (rsp_parent_vertex !== e.parent) begin
               $error("parent_vertex exp %0d got %0d", e.parent, rsp_parent_vertex);
               mismatches++;
            end
            if (rsp_has_parent !== e.parent_ok) begin
               $error("has_parent exp %0d got %0d", e.parent_ok, rsp_has_parent); mismatches++;
            end
            if (rsp_last_result !== e.last) begin
               $error("last_result exp %0d got %0d", e.last, rsp_last_result); mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [4:0] data);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_VERTEX_COUNT) model_vertex_count = data;
      else model_source = data[3:0];
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic add_entry(int f, int t, int w, bit eog);
      edge_item_type it;
      it.from_v = 4'(f);
      it.to_v = 4'(t);
      it.weight = 16'(w);
      it.last_entry = eog;
      entry_queue.push_back(it);
      item_total++;
   endtask

   // drain: all transactions sent, all results in, block back to idle
   task automatic wait_quiet();
      while (entry_queue.size() > 0 || sending || gap_left > 0 || expected_paths.size() > 0)
         @(posedge clock);
      while (busy) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic configure(int vc, int sv);
      write_reg(CSR_VERTEX_COUNT, 5'(vc));
      write_reg(CSR_START_VERTEX, 5'(sv));
   endtask

   // random graph: mostly edges inside the active vertices, some noise
   task automatic random_graph(int nv);
      int n, f, t, w;
      n = $urandom_range(0, 12);
      for (int k = 0; k <= n; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            f = $urandom_range(0, 15); t = $urandom_range(0, 15);
         end else begin
            f = $urandom_range(0, nv - 1); t = $urandom_range(0, nv - 1);
         end
         case ($urandom_range(0, 5))
            0: w = $signed(16'($urandom));
            1: w = 0;
            2: w = $urandom_range(0, 1) ? 32767 : -32768;
            default: w = $urandom_range(0, 150) - 30;
         endcase
         add_entry(f, t, w, k == n);
      end
   endtask

   initial begin
      int vc, nv, sv;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: default registers, extreme weights and vertices
      add_entry(0, 1, 32767, 0);
      add_entry(1, 2, -32768, 0);
      add_entry(15, 15, -1, 0);
      add_entry(2, 3, 0, 0);
      add_entry(2, 15, 100, 0);
      add_entry(0, 15, 5, 1);
      wait_quiet();
      // zero vertex count acts as one
      configure(0, 0);
      add_entry(0, 0, 7, 1);
      wait_quiet();
      // negative cycle built from the most negative weight
      configure(2, 1);
      add_entry(0, 1, -32768, 0);
      add_entry(1, 0, -32768, 0);
      add_entry(1, 1, 0, 1);
      wait_quiet();
      // oversized count clamps to sixteen, source at the top vertex
      configure(31, 15);
      add_entry(15, 0, 1, 0);
      add_entry(0, 3, -5, 0);
      add_entry(3, 15, 2, 1);
      wait_quiet();
      // source outside the active vertices
      configure(4, 9);
      add_entry(0, 1, 3, 1);
      wait_quiet();
      configure(16, 0);

      // random phases
      while (item_total < 430) begin
         case ($urandom_range(0, 11))
            0: vc = 0;
            1: vc = $urandom_range(16, 31);
            default: vc = $urandom_range(1, 8);
         endcase
         nv = (vc < 1) ? 1 : (vc > 16 ? 16 : vc);
         sv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, nv - 1);
         configure(vc, sv);
         repeat ($urandom_range(1, 4)) random_graph(nv);
         wait_quiet();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_paths.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/sssp_pkg.sv
rtl/core/sssp_ram.sv
rtl/core/sssp_cell.sv
rtl/core/single_source_shortest_paths_top.sv
tb/tb_single_source_shortest_paths_top.sv
